// File: rtl/core/xorshift128p_ranged_random_assert.svh
// Assertion macros for the top level of the random source RTL.
`ifndef XORSHIFT128P_RANGED_RANDOM_ASSERT_SVH
`define XORSHIFT128P_RANGED_RANDOM_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define XRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define XRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/xrr_pkg.sv
// Shared types and constants of the ranged xorshift128+ random source.
package xrr_pkg;

  // Splitmix64 finalizer constants.
  localparam logic [63:0] SM_GOLDEN     = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MUL_A      = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MUL_B      = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] SM_ZERO_SUBST = 64'h18A2_70F2_4D80_907B;
  localparam int unsigned SM_SHIFT_1    = 30;
  localparam int unsigned SM_SHIFT_2    = 27;
  localparam int unsigned SM_SHIFT_3    = 31;

  // Xorshift128+ shift amounts.
  localparam int unsigned XS_SHIFT_A = 23;
  localparam int unsigned XS_SHIFT_B = 18;
  localparam int unsigned XS_SHIFT_C = 5;

  // Divider sizing: one quotient bit per cycle over the 64-bit draw.
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

  // Command queue between the front and the back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    CMD_RAW,
    CMD_BAD,
    CMD_FULL,
    CMD_RANGED
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [63:0] lo;
    logic [63:0] span;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic seed_busy;
    logic pop;
  } back_stat_t;

  typedef enum logic [2:0] {
    SD_IDLE,
    SD_A0,
    SD_A1,
    SD_A2,
    SD_B0,
    SD_B1,
    SD_B2,
    SD_STORE
  } seed_st_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_st_e;

endpackage

// File: rtl/core/xrr_if.sv
// Request and response channel interfaces of the random source.
interface xrr_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [63:0] range_low;
  logic signed [63:0] range_high;

  modport source (output valid, output kind, output range_low, output range_high,
                  input ready);
  modport sink (input valid, input kind, input range_low, input range_high,
                output ready);
endinterface

interface xrr_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        bad_range;

  modport source (output valid, output value, output bad_range, input ready);
  modport sink (input valid, input value, input bad_range, output ready);
endinterface

// File: rtl/core/xrr_front.sv
// Request front end: accepts items and classifies them into queue commands.
module xrr_front (
  xrr_req_if.sink          req_i,
  input  xrr_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output xrr_pkg::cmd_t    wdata_o
);
  import xrr_pkg::*;

  logic [63:0] span;
  logic        bad;

  assign span = req_i.range_high - req_i.range_low + 64'd1;
  assign bad  = req_i.range_low > req_i.range_high;

  assign req_i.ready = !q_stat_i.full;
  assign push_o      = req_i.valid && !q_stat_i.full;

  always_comb begin
    wdata_o.lo   = req_i.range_low;
    wdata_o.span = span;
    if (!req_i.kind) begin
      wdata_o.kind = CMD_RAW;
    end else if (bad) begin
      wdata_o.kind = CMD_BAD;
    end else if (span == 64'd0) begin
      wdata_o.kind = CMD_FULL;
    end else begin
      wdata_o.kind = CMD_RANGED;
    end
  end

endmodule

// File: rtl/core/xrr_fifo.sv
// Short command queue between the front end and the back end.
module xrr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xrr_pkg::cmd_t    wdata_i,
  input  logic             pop_i,
  output xrr_pkg::cmd_t    rdata_o,
  output xrr_pkg::q_stat_t stat_o
);
  import xrr_pkg::*;

  cmd_t              mem_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_q;
  logic [Q_AW-1:0]   rd_ptr_q;
  logic [Q_AW:0]     count_q;
  logic [Q_AW:0]     count_d;

  assign stat_o.full  = count_q == (Q_AW + 1)'(Q_DEPTH);
  assign stat_o.empty = count_q == '0;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/core/xrr_back.sv
// Back end: generator state, splitmix seeding, range divider and result register.
module xrr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                seed_we_i,
  input  logic [63:0]         seed_wdata_i,
  input  xrr_pkg::q_stat_t    q_stat_i,
  input  xrr_pkg::cmd_t       q_rdata_i,
  xrr_rsp_if.source           rsp_o,
  output xrr_pkg::back_stat_t stat_o
);
  import xrr_pkg::*;

  // Generator and seeding state.
  logic [63:0] gen_a_q, gen_a_d;
  logic [63:0] gen_b_q, gen_b_d;
  logic [63:0] seed_q, seed_d;
  logic [63:0] w_q, w_d;
  logic [63:0] acc_q, acc_d;
  logic        pass_q, pass_d;
  seed_st_e    sd_q, sd_d;

  // Item processing state.
  back_st_e        bk_q, bk_d;
  logic [63:0]     lo_q, lo_d;
  logic [63:0]     span_q, span_d;
  logic [63:0]     rem_q, rem_d;
  logic [63:0]     dvd_q, dvd_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic            rsp_valid_q, rsp_valid_d;
  logic [63:0]     rsp_value_q, rsp_value_d;
  logic            rsp_bad_q, rsp_bad_d;

  // Combinational helpers.
  logic        out_free;
  logic        pop;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] prod;
  logic [63:0] mix_t;
  logic [63:0] mix_f;
  logic [63:0] reseed_sum;
  logic [63:0] load_sum;
  logic [63:0] xs_t0;
  logic [63:0] xs_t1;
  logic [63:0] next_b;
  logic [63:0] draw;
  logic [64:0] trial;
  logic [64:0] diff;

  // One xorshift128+ step from the current state words.
  assign xs_t0  = gen_a_q ^ (gen_a_q << XS_SHIFT_A);
  assign xs_t1  = xs_t0 ^ (xs_t0 >> XS_SHIFT_B);
  assign next_b = xs_t1 ^ gen_b_q ^ (gen_b_q >> XS_SHIFT_C);
  assign draw   = next_b + gen_b_q;

  // Shared 32x32 multiplier; the 64-bit low product is built in three passes.
  always_comb begin
    unique case (sd_q)
      SD_A0: begin
        mul_x = w_q[31:0];
        mul_y = SM_MUL_A[31:0];
      end
      SD_A1: begin
        mul_x = w_q[31:0];
        mul_y = SM_MUL_A[63:32];
      end
      SD_A2: begin
        mul_x = w_q[63:32];
        mul_y = SM_MUL_A[31:0];
      end
      SD_B0: begin
        mul_x = w_q[31:0];
        mul_y = SM_MUL_B[31:0];
      end
      SD_B1: begin
        mul_x = w_q[31:0];
        mul_y = SM_MUL_B[63:32];
      end
      SD_B2: begin
        mul_x = w_q[63:32];
        mul_y = SM_MUL_B[31:0];
      end
      SD_IDLE, SD_STORE: begin
        mul_x = w_q[31:0];
        mul_y = SM_MUL_A[31:0];
      end
    endcase
  end

  assign prod       = mul_x * mul_y;
  assign mix_t      = acc_q + {prod[31:0], 32'd0};
  assign mix_f      = mix_t ^ (mix_t >> SM_SHIFT_3);
  assign reseed_sum = seed_q + w_q + SM_GOLDEN;
  assign load_sum   = seed_wdata_i + SM_GOLDEN;

  // Restoring divider step.
  assign trial = {rem_q, dvd_q[63]};
  assign diff  = trial - {1'b0, span_q};

  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    gen_a_d     = gen_a_q;
    gen_b_d     = gen_b_q;
    seed_d      = seed_q;
    w_d         = w_q;
    acc_d       = acc_q;
    pass_d      = pass_q;
    sd_d        = sd_q;
    bk_d        = bk_q;
    lo_d        = lo_q;
    span_d      = span_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    cnt_d       = cnt_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_value_d = rsp_value_q;
    rsp_bad_d   = rsp_bad_q;
    pop         = 1'b0;

    // Seeding sequencer.
    unique case (sd_q)
      SD_IDLE: begin
      end
      SD_A0: begin
        acc_d = prod;
        sd_d  = SD_A1;
      end
      SD_A1: begin
        acc_d = mix_t;
        sd_d  = SD_A2;
      end
      SD_A2: begin
        w_d  = mix_t ^ (mix_t >> SM_SHIFT_2);
        sd_d = SD_B0;
      end
      SD_B0: begin
        acc_d = prod;
        sd_d  = SD_B1;
      end
      SD_B1: begin
        acc_d = mix_t;
        sd_d  = SD_B2;
      end
      SD_B2: begin
        w_d  = (mix_f == 64'd0) ? SM_ZERO_SUBST : mix_f;
        sd_d = SD_STORE;
      end
      SD_STORE: begin
        if (!pass_q) begin
          gen_a_d = w_q;
          w_d     = reseed_sum ^ (reseed_sum >> SM_SHIFT_1);
          pass_d  = 1'b1;
          sd_d    = SD_A0;
        end else begin
          gen_b_d = w_q;
          sd_d    = SD_IDLE;
        end
      end
    endcase

    // Item sequencer.
    unique case (bk_q)
      BK_IDLE: begin
        if (!q_stat_i.empty && (sd_q == SD_IDLE) && out_free) begin
          pop = 1'b1;
          unique case (q_rdata_i.kind)
            CMD_RAW: begin
              gen_a_d     = gen_b_q;
              gen_b_d     = next_b;
              rsp_valid_d = 1'b1;
              rsp_value_d = draw;
              rsp_bad_d   = 1'b0;
            end
            CMD_BAD: begin
              rsp_valid_d = 1'b1;
              rsp_value_d = 64'd0;
              rsp_bad_d   = 1'b1;
            end
            CMD_FULL: begin
              gen_a_d     = gen_b_q;
              gen_b_d     = next_b;
              rsp_valid_d = 1'b1;
              rsp_value_d = draw + q_rdata_i.lo;
              rsp_bad_d   = 1'b0;
            end
            CMD_RANGED: begin
              gen_a_d = gen_b_q;
              gen_b_d = next_b;
              lo_d    = q_rdata_i.lo;
              span_d  = q_rdata_i.span;
              rem_d   = 64'd0;
              dvd_d   = draw;
              cnt_d   = '0;
              bk_d    = BK_DIV;
            end
          endcase
        end
      end
      BK_DIV: begin
        rem_d = diff[64] ? trial[63:0] : diff[63:0];
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
          bk_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_value_d = lo_q + rem_q;
          rsp_bad_d   = 1'b0;
          bk_d        = BK_IDLE;
        end
      end
      default: begin
        bk_d = BK_IDLE;
      end
    endcase

    // A seed write restarts the seeding sequence.
    if (seed_we_i) begin
      seed_d = seed_wdata_i;
      w_d    = load_sum ^ (load_sum >> SM_SHIFT_1);
      pass_d = 1'b0;
      sd_d   = SD_A0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_a_q     <= 64'd0;
      gen_b_q     <= 64'd1;
      seed_q      <= 64'd0;
      pass_q      <= 1'b0;
      sd_q        <= SD_IDLE;
      bk_q        <= BK_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      gen_a_q     <= gen_a_d;
      gen_b_q     <= gen_b_d;
      seed_q      <= seed_d;
      pass_q      <= pass_d;
      sd_q        <= sd_d;
      bk_q        <= bk_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q         <= w_d;
    acc_q       <= acc_d;
    lo_q        <= lo_d;
    span_q      <= span_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    cnt_q       <= cnt_d;
    rsp_value_q <= rsp_value_d;
    rsp_bad_q   <= rsp_bad_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.value     = rsp_value_q;
  assign rsp_o.bad_range = rsp_bad_q;

  assign stat_o.seed_busy = sd_q != SD_IDLE;
  assign stat_o.pop       = pop;

endmodule

// File: rtl/core/xorshift128p_ranged_random.sv
// Top level of the ranged xorshift128+ random source.
//
// This block is an xorshift128+ random source with splitmix64 seeding. Each
// request on req_i returns one result on rsp_o and, unless its range is bad,
// advances the two 64-bit state words once: a raw request (kind 0) returns the
// 64-bit sum output, and a ranged request (kind 1) returns range_low plus the
// draw modulo the span range_high - range_low + 1. When the span covers all
// 2^64 values, the draw plus range_low is returned. When range_low is above
// range_high (signed compare), bad_range is set, value is zero and the state
// does not move. A front end accepts and classifies requests into a two-entry
// command queue, so until it is full requests keep being taken while the back
// end works or while a result waits in the output register. Raw, full-span and
// bad-range requests finish in the back end's idle state, so they can stream
// at one item per cycle while rsp_o is ready and no reseed runs. A ranged
// request with a nonzero span advances the state, runs the restoring divider
// (one quotient bit per cycle) and adds the lower bound; that divider sets the
// rate of ranged draws. A write to the seed register (seed_we_i) reloads both
// state words through the splitmix64 finalizer, built on one shared 32x32
// multiplier, while queued requests wait. Seed writes must be made by the user
// only while no request is outstanding; the block does not enforce this.
module xorshift128p_ranged_random (
  input  logic        clk_i,
  input  logic        rst_ni,
  xrr_req_if.sink     req_i,
  xrr_rsp_if.source   rsp_o,
  input  logic        seed_we_i,
  input  logic [63:0] seed_wdata_i
);
  import xrr_pkg::*;

  logic       q_push;
  cmd_t       q_wdata;
  cmd_t       q_rdata;
  q_stat_t    q_stat;
  back_stat_t bk_stat;

  // Classification of incoming items.
  xrr_front u_front (
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .wdata_o  (q_wdata)
  );

  // Command queue decoupling the front from the back.
  xrr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (bk_stat.pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  // Generator, seeding, divider and result register.
  xrr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_wdata_i (seed_wdata_i),
    .q_stat_i     (q_stat),
    .q_rdata_i    (q_rdata),
    .rsp_o        (rsp_o),
    .stat_o       (bk_stat)
  );

`include "xorshift128p_ranged_random_assert.svh"

  // The back end never takes a command from an empty queue.
  `XRR_ASSERT(a_pop_nonempty, !(bk_stat.pop && q_stat.empty), "pop from empty queue")
  // No command is executed while the state words are being reseeded.
  `XRR_ASSERT(a_no_pop_seeding, !(bk_stat.pop && bk_stat.seed_busy), "pop during seeding")
  // A seed write always starts the reseed sequence.
  `XRR_ASSERT_NEXT(a_seed_starts, seed_we_i, bk_stat.seed_busy, "seed write not taken")
  // A bad range result always carries a zero value.
  `XRR_ASSERT(a_bad_zero, !(rsp_o.valid && rsp_o.bad_range && |rsp_o.value), "bad range value")

endmodule
